// ===== design/vector_distance_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Vector distance unit assertion macros
// Concurrent assertion wrappers, used by the vdu_ctrl design module.
// ----------------------------------------------------------------------------
`ifndef VECTOR_DISTANCE_UNIT_DEFINES_SVH
`define VECTOR_DISTANCE_UNIT_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define VDU_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define VDU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/vdu_pkg.sv =====
// ----------------------------------------------------------------------------
// Vector distance unit package
// Shared types and constants between controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vdu_pkg;

    localparam logic [1:0] METRIC_EUCLID    = 2'd0;
    localparam logic [1:0] METRIC_MANHATTAN = 2'd1;
    localparam logic [1:0] METRIC_COSINE    = 2'd2;

    localparam logic REG_METRIC     = 1'b0;
    localparam logic REG_NORMALISED = 1'b1;

    localparam int ELEM_W = 16;
    localparam int SQ_W   = 44;
    localparam int ABS_W  = 30;
    localparam int DOT_W  = 45;
    localparam int NORM_W = 44;

    typedef struct packed {
        logic norm_load_a;
        logic norm_load_b;
        logic norm_step;
        logic sqrt_start;
        logic sqrt_euclid;
        logic root_a_store;
        logic root_b_store;
        logic div_load;
        logic div_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic       last_acc;
        logic       norm_ok;
        logic       sqrt_busy;
        logic       sqrt_done;
        logic       div_done;
        logic       out_free;
        logic [1:0] metric;
        logic       normalised;
        logic       zero_mag;
    } t_stat;

endpackage

`default_nettype wire

// ===== design/vector_distance_unit.sv =====
// Pipeline: an element pair enters per cycle; its sums update after the r_v1 and r_v2 stages.
// After the last pair: manhattan, normalized cosine and zero magnitude take ST_DRAIN, ST_DECIDE
// and ST_DONE; euclidean adds a 32-step square root; full cosine adds two normalizing shifts of
// up to 30 steps, two 32-step roots and up to a 90-step long division; output stalls add on.
// Throughput: 1 pair per cycle within a vector; input is held off until the result loads.
// Reset: synchronous active low; clears sums, valid flags, configuration, controller state and output valid.
`timescale 1ns / 1ps
`default_nettype none

module vector_distance_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [31:0] i_s_tdata,   // [15:0] elem_a, [31:16] elem_b
    input  wire logic        i_s_tlast,   // last_elem
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [31:0]      o_m_tdata,   // [31:0] distance
    output logic             o_m_tuser,   // [0] zero_magnitude
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_addr,
    input  wire logic [1:0]  i_cfg_wdata
);

    vdu_pkg::t_cmd  cmd;
    vdu_pkg::t_stat stat;
    logic           ready;
    logic           accept;

    assign accept     = i_s_tvalid & ready;
    assign o_s_tready = ready;

    vdu_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_last   (i_s_tlast),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .o_ready  (ready)
    );

    vdu_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data      (i_s_tdata),
        .i_last      (i_s_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_out_ready (i_m_tready),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_m_tvalid),
        .o_out_dist  (o_m_tdata),
        .o_out_zero  (o_m_tuser)
    );

endmodule

`default_nettype wire

// ===== design/vdu_sqrt.sv =====
// ----------------------------------------------------------------------------
// Vector distance unit square root
// Bit-serial integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vdu_sqrt (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_x,
    output logic             o_busy,
    output logic             o_done,
    output logic [31:0]      o_root
);

    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [63:0] r_x, n_x;
    logic [63:0] r_r, n_r;
    logic [63:0] r_bit, n_bit;
    logic [63:0] trial;

    always_comb begin
        trial  = r_r + r_bit;
        n_busy = r_busy;
        n_done = 1'b0;
        n_x    = r_x;
        n_r    = r_r;
        n_bit  = r_bit;
        if (i_start) begin
            n_busy = 1'b1;
            n_x    = i_x;
            n_r    = '0;
            n_bit  = 64'd1 << 62;
        end else if (r_busy) begin
            if (r_x >= trial) begin
                n_x = r_x - trial;
                n_r = (r_r >> 1) + r_bit;
            end else begin
                n_r = r_r >> 1;
            end
            n_bit = r_bit >> 2;
            if (r_bit[0]) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_x   <= n_x;
        r_r   <= n_r;
        r_bit <= n_bit;
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_root = r_r[31:0];

endmodule

`default_nettype wire

// ===== design/vdu_datapath.sv =====
// ----------------------------------------------------------------------------
// Vector distance unit datapath
// Element pipeline, saturating sums, root/divide registers and result stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vdu_datapath (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_accept,
    input  wire logic [31:0]   i_data,
    input  wire logic          i_last,
    input  wire logic          i_cfg_we,
    input  wire logic          i_cfg_addr,
    input  wire logic [1:0]    i_cfg_wdata,
    input  wire logic          i_out_ready,
    input  wire vdu_pkg::t_cmd i_cmd,
    output vdu_pkg::t_stat     o_stat,
    output logic               o_out_valid,
    output logic [31:0]        o_out_dist,
    output logic               o_out_zero
);

    // configuration
    logic [1:0] r_metric;
    logic       r_normalised;

    // element pipeline
    logic        r_v1, r_last1, r_neg1;
    logic [15:0] r_ma, r_mb, r_md;
    logic        r_v2, r_last2, r_neg2;
    logic [31:0] r_sq, r_na, r_nb, r_p;
    logic [15:0] r_md2;

    logic signed [15:0] elem_a, elem_b;
    logic signed [16:0] diff;
    logic [16:0]        diff_mag;

    // sums
    logic [vdu_pkg::SQ_W-1:0]          r_sq_sum;
    logic [vdu_pkg::ABS_W-1:0]         r_abs_sum;
    logic signed [vdu_pkg::DOT_W-1:0]  r_dot_sum;
    logic [vdu_pkg::NORM_W-1:0]        r_na_sum, r_nb_sum;
    logic [vdu_pkg::SQ_W:0]            sq_add;
    logic [vdu_pkg::ABS_W:0]           abs_add;
    logic [vdu_pkg::NORM_W:0]          na_add, nb_add;
    logic signed [vdu_pkg::DOT_W:0]    dot_add;

    // finish
    logic [63:0] r_norm;
    logic [4:0]  r_half, r_half_a, r_half_b;
    logic [30:0] r_root_a, r_root_b;
    logic [61:0] r_den;
    logic [62:0] r_rem;
    logic [31:0] r_q;
    logic [6:0]  r_cnt;
    logic [63:0] rem_sh;
    logic [63:0] sqrt_x;
    logic        sqrt_busy, sqrt_done;
    logic [31:0] sqrt_root;
    logic [44:0] dot_mag;

    // result
    logic        r_out_valid;
    logic [31:0] r_out_dist;
    logic        r_out_zero;
    logic [31:0] res_dist;
    logic        res_zero;
    logic [31:0] q_c;
    logic [31:0] d_full;
    logic [45:0] d_unit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_metric     <= vdu_pkg::METRIC_EUCLID;
            r_normalised <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                vdu_pkg::REG_METRIC:     r_metric     <= i_cfg_wdata;
                vdu_pkg::REG_NORMALISED: r_normalised <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        elem_a   = i_data[15:0];
        elem_b   = i_data[31:16];
        diff     = {elem_a[15], elem_a} - {elem_b[15], elem_b};
        diff_mag = diff[16] ? (~diff + 17'd1) : diff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_accept;
            r_v2 <= r_v1;
        end
        r_last1 <= i_last;
        r_neg1  <= elem_a[15] ^ elem_b[15];
        r_ma    <= elem_a[15] ? (~elem_a + 16'd1) : elem_a;
        r_mb    <= elem_b[15] ? (~elem_b + 16'd1) : elem_b;
        r_md    <= diff_mag[15:0];
        r_last2 <= r_last1;
        r_neg2  <= r_neg1;
        r_md2   <= r_md;
        r_sq    <= r_md * r_md;
        r_na    <= r_ma * r_ma;
        r_nb    <= r_mb * r_mb;
        r_p     <= r_ma * r_mb;
    end

    always_comb begin
        sq_add  = {1'b0, r_sq_sum} + {13'd0, r_sq};
        abs_add = {1'b0, r_abs_sum} + {15'd0, r_md2};
        na_add  = {1'b0, r_na_sum} + {13'd0, r_na};
        nb_add  = {1'b0, r_nb_sum} + {13'd0, r_nb};
        if (r_neg2)
            dot_add = {r_dot_sum[44], r_dot_sum} - $signed({14'd0, r_p});
        else
            dot_add = {r_dot_sum[44], r_dot_sum} + $signed({14'd0, r_p});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.out_load) begin
            r_sq_sum  <= '0;
            r_abs_sum <= '0;
            r_dot_sum <= '0;
            r_na_sum  <= '0;
            r_nb_sum  <= '0;
        end else if (r_v2) begin
            r_sq_sum  <= sq_add[44]  ? {vdu_pkg::SQ_W{1'b1}}   : sq_add[43:0];
            r_abs_sum <= abs_add[30] ? {vdu_pkg::ABS_W{1'b1}}  : abs_add[29:0];
            r_na_sum  <= na_add[44]  ? {vdu_pkg::NORM_W{1'b1}} : na_add[43:0];
            r_nb_sum  <= nb_add[44]  ? {vdu_pkg::NORM_W{1'b1}} : nb_add[43:0];
            if (dot_add[45] == dot_add[44])
                r_dot_sum <= dot_add[44:0];
            else if (dot_add[45])
                r_dot_sum <= {1'b1, 44'd0};
            else
                r_dot_sum <= {1'b0, {44{1'b1}}};
        end
    end

    assign sqrt_x = i_cmd.sqrt_euclid ? {18'd0, r_sq_sum, 2'b00} : r_norm;

    vdu_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.sqrt_start),
        .i_x     (sqrt_x),
        .o_busy  (sqrt_busy),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

    assign dot_mag = r_dot_sum[44] ? (~r_dot_sum + 45'd1) : r_dot_sum;
    assign rem_sh  = {r_rem, 1'b0};

    always_ff @(posedge i_clk) begin
        if (i_cmd.norm_load_a) begin
            r_norm <= {20'd0, r_na_sum};
            r_half <= '0;
        end else if (i_cmd.norm_load_b) begin
            r_norm <= {20'd0, r_nb_sum};
            r_half <= '0;
        end else if (i_cmd.norm_step) begin
            r_norm <= r_norm << 2;
            r_half <= r_half + 5'd1;
        end
        if (i_cmd.root_a_store) begin
            r_root_a <= sqrt_root[30:0];
            r_half_a <= r_half;
        end
        if (i_cmd.root_b_store) begin
            r_root_b <= sqrt_root[30:0];
            r_half_b <= r_half;
        end
        if (i_cmd.div_load) begin
            r_den <= r_root_a * r_root_b;
            r_rem <= {18'd0, dot_mag};
            r_q   <= '0;
            r_cnt <= {2'b00, r_half_a} + {2'b00, r_half_b} + 7'd30;
        end else if (i_cmd.div_step) begin
            r_cnt <= r_cnt - 7'd1;
            if (rem_sh >= {2'b00, r_den}) begin
                r_rem <= rem_sh[62:0] - {1'b0, r_den};
                r_q   <= {r_q[30:0], 1'b1};
            end else begin
                r_rem <= rem_sh[62:0];
                r_q   <= {r_q[30:0], 1'b0};
            end
        end
    end

    // result select
    always_comb begin
        q_c = r_q[31] ? 32'h8000_0000 : r_q;
        if (!r_dot_sum[44])
            d_full = (q_c >= 32'h4000_0000) ? 32'd0 : 32'h4000_0000 - q_c;
        else
            d_full = (q_c >= 32'h4000_0000) ? 32'h8000_0000 : 32'h4000_0000 + q_c;
        if (!r_dot_sum[44])
            d_unit = (r_dot_sum >= 45'sh4000_0000) ? 46'd0
                     : 46'h4000_0000 - {1'b0, r_dot_sum};
        else if (dot_mag >= 45'h4000_0000)
            d_unit = 46'h8000_0000;
        else
            d_unit = 46'h4000_0000 + {1'b0, dot_mag};
        res_dist = '0;
        res_zero = 1'b0;
        unique case (r_metric)
            vdu_pkg::METRIC_EUCLID:    res_dist = sqrt_root;
            vdu_pkg::METRIC_MANHATTAN: res_dist = {1'b0, r_abs_sum, 1'b0};
            vdu_pkg::METRIC_COSINE: begin
                if (r_normalised)
                    res_dist = {14'd0, d_unit[31:14]};
                else if (r_na_sum == '0 || r_nb_sum == '0)
                    res_zero = 1'b1;
                else
                    res_dist = {14'd0, d_full[31:14]};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_out_dist <= res_dist;
            r_out_zero <= res_zero;
        end
    end

    always_comb begin
        o_stat.last_acc   = r_v2 & r_last2;
        o_stat.norm_ok    = |r_norm[63:60];
        o_stat.sqrt_busy  = sqrt_busy;
        o_stat.sqrt_done  = sqrt_done;
        o_stat.div_done   = (r_cnt == 7'd0) | r_q[31];
        o_stat.out_free   = !r_out_valid | i_out_ready;
        o_stat.metric     = r_metric;
        o_stat.normalised = r_normalised;
        o_stat.zero_mag   = (r_na_sum == '0) | (r_nb_sum == '0);
    end

    assign o_out_valid = r_out_valid;
    assign o_out_dist  = r_out_dist;
    assign o_out_zero  = r_out_zero;

endmodule

`default_nettype wire

// ===== design/vdu_ctrl.sv =====
// ----------------------------------------------------------------------------
// Vector distance unit controller
// Sequences accumulation, normalizing shifts, square roots, division and result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "vector_distance_unit_defines.svh"

module vdu_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_accept,
    input  wire logic           i_last,
    input  wire vdu_pkg::t_stat i_stat,
    output vdu_pkg::t_cmd       o_cmd,
    output logic                o_ready
);

    localparam logic [3:0] ST_RUN    = 4'd0;
    localparam logic [3:0] ST_DRAIN  = 4'd1;
    localparam logic [3:0] ST_DECIDE = 4'd2;
    localparam logic [3:0] ST_EUC    = 4'd3;
    localparam logic [3:0] ST_NA_SH  = 4'd4;
    localparam logic [3:0] ST_NA_RT  = 4'd5;
    localparam logic [3:0] ST_NB_SH  = 4'd6;
    localparam logic [3:0] ST_NB_RT  = 4'd7;
    localparam logic [3:0] ST_MUL    = 4'd8;
    localparam logic [3:0] ST_DIV    = 4'd9;
    localparam logic [3:0] ST_DONE   = 4'd10;

    logic [3:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_RUN: begin
                if (i_accept && i_last) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (i_stat.last_acc) n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (i_stat.metric == vdu_pkg::METRIC_EUCLID) begin
                    o_cmd.sqrt_start  = 1'b1;
                    o_cmd.sqrt_euclid = 1'b1;
                    n_state           = ST_EUC;
                end else if (i_stat.metric == vdu_pkg::METRIC_COSINE &&
                             !i_stat.normalised && !i_stat.zero_mag) begin
                    o_cmd.norm_load_a = 1'b1;
                    n_state           = ST_NA_SH;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_EUC: begin
                if (i_stat.sqrt_done) n_state = ST_DONE;
            end
            ST_NA_SH: begin
                if (i_stat.norm_ok) begin
                    o_cmd.sqrt_start = 1'b1;
                    n_state          = ST_NA_RT;
                end else begin
                    o_cmd.norm_step = 1'b1;
                end
            end
            ST_NA_RT: begin
                if (i_stat.sqrt_done) begin
                    o_cmd.root_a_store = 1'b1;
                    o_cmd.norm_load_b  = 1'b1;
                    n_state            = ST_NB_SH;
                end
            end
            ST_NB_SH: begin
                if (i_stat.norm_ok) begin
                    o_cmd.sqrt_start = 1'b1;
                    n_state          = ST_NB_RT;
                end else begin
                    o_cmd.norm_step = 1'b1;
                end
            end
            ST_NB_RT: begin
                if (i_stat.sqrt_done) begin
                    o_cmd.root_b_store = 1'b1;
                    n_state            = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.div_load = 1'b1;
                n_state        = ST_DIV;
            end
            ST_DIV: begin
                if (i_stat.div_done) n_state = ST_DONE;
                else o_cmd.div_step = 1'b1;
            end
            ST_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_RUN;
                end
            end
            default: n_state = ST_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == ST_RUN);

    `VDU_ASSERT(a_load_free, i_clk, i_rst_n, o_cmd.out_load |-> i_stat.out_free, "result overwritten")
    `VDU_ASSERT(a_drain_next, i_clk, i_rst_n, (r_state == ST_DRAIN && i_stat.last_acc) |=> (r_state == ST_DECIDE), "drain exit lost")
    `VDU_ASSERT(a_sqrt_idle, i_clk, i_rst_n, o_cmd.sqrt_start |-> !i_stat.sqrt_busy, "sqrt restarted while busy")
    `VDU_ASSERT(a_no_acc_busy, i_clk, i_rst_n, (r_state != ST_RUN) |-> !i_accept, "item taken during finish")

endmodule

`default_nettype wire
